FILE: hw/rtl/alias_method_sampler_xoroshiro_defines.svh
// assertion macros for the alias sampler checker
// both expect clk and arst_n in scope
`ifndef ALIAS_METHOD_SAMPLER_XOROSHIRO_DEFINES_SVH
`define ALIAS_METHOD_SAMPLER_XOROSHIRO_DEFINES_SVH

// consequent must hold in the same cycle
`define AMSX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("amsx checker: same-cycle property failed");

// consequent must hold in the next cycle
`define AMSX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("amsx checker: next-cycle property failed");

`endif

FILE: hw/rtl/amsx_pkg.sv
`timescale 1ns / 1ps

package amsx_pkg;

	// default parameter values
	localparam int unsigned DEF_TABLE_DEPTH       = 4096;
	localparam int unsigned DEF_TOKEN_WIDTH       = 16;
	localparam int unsigned DEF_CUT_FRACTION_BITS = 16;
	localparam int unsigned DEF_MAX_REDRAWS       = 64;

	// fixed field widths
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned CUT_W   = 17;
	localparam int unsigned TOK_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned UNI_W   = 53;

	// shared multiplier operand widths
	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// generator constants
	localparam logic [WORD_W-1:0] SEED_LOW_RST  = 64'd1;
	localparam logic [WORD_W-1:0] SEED_HIGH_RST = 64'd0;
	localparam int unsigned ROT_A   = 24;
	localparam int unsigned SHIFT_B = 16;
	localparam int unsigned ROT_B   = 37;
	localparam int unsigned UNI_SHIFT = 11;
	localparam int unsigned JUMP_STEPS = 128;
	localparam logic [2*WORD_W-1:0] JUMP_POLY = {64'h170865df4b3201fc, 64'hdf900294d8f554a5};

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_JUMP   = 2'd2,
		REQ_RESEED = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_SAMPLED   = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_DONE      = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_SIZE  = 3'd0,
		CFG_SKIP_ID     = 3'd1,
		CFG_SKIP_ENABLE = 3'd2,
		CFG_SEED_LOW    = 3'd3,
		CFG_SEED_HIGH   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MODQ,
		S_MODM,
		S_MODR,
		S_WR,
		S_DRAW,
		S_MLO,
		S_MHI,
		S_RD,
		S_PICK,
		S_ALIAS,
		S_JUMP
	} state_t;

	// generator control from the sequencer
	typedef struct packed {
		logic step;
		logic reseed;
		logic acc_clear;
		logic acc_xor;
		logic acc_load;
	} gen_cmd_t;

endpackage

FILE: hw/rtl/amsx_ram.sv
`timescale 1ns / 1ps

module amsx_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: hw/rtl/amsx_mul.sv
`timescale 1ns / 1ps

module amsx_mul (
	input  logic                        clk,
	input  logic [amsx_pkg::MUL_A_W-1:0] a,
	input  logic [amsx_pkg::MUL_B_W-1:0] b,
	output logic [amsx_pkg::MUL_P_W-1:0] p_q
);

	import amsx_pkg::*;

	// shared multiplier with registered product
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

FILE: hw/rtl/amsx_gen.sv
`timescale 1ns / 1ps

module amsx_gen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  amsx_pkg::gen_cmd_t          cmd,
	input  logic [amsx_pkg::WORD_W-1:0] seed_low,
	input  logic [amsx_pkg::WORD_W-1:0] seed_high,
	output logic [amsx_pkg::WORD_W-1:0] sum
);

	import amsx_pkg::*;

	logic [WORD_W-1:0] a_q, b_q;
	logic [WORD_W-1:0] acc_a_q, acc_b_q;
	logic [WORD_W-1:0] mix, next_a, next_b;
	logic [WORD_W-1:0] acc_a_d, acc_b_d;

	// one xoroshiro128+ step
	always_comb begin
		mix    = a_q ^ b_q;
		next_a = ((a_q << ROT_A) | (a_q >> (WORD_W - ROT_A))) ^ mix ^ (mix << SHIFT_B);
		next_b = (mix << ROT_B) | (mix >> (WORD_W - ROT_B));
		sum    = a_q + b_q;
	end

	// jump accumulator with this cycle's term folded in
	always_comb begin
		acc_a_d = cmd.acc_xor ? (acc_a_q ^ a_q) : acc_a_q;
		acc_b_d = cmd.acc_xor ? (acc_b_q ^ b_q) : acc_b_q;
	end

	// generator words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= SEED_LOW_RST;
			b_q <= SEED_HIGH_RST;
		end else if (cmd.reseed) begin
			a_q <= seed_low;
			b_q <= seed_high;
		end else if (cmd.acc_load) begin
			a_q <= acc_a_d;
			b_q <= acc_b_d;
		end else if (cmd.step) begin
			a_q <= next_a;
			b_q <= next_b;
		end
	end

	// jump accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else begin
			acc_a_q <= acc_a_d;
			acc_b_q <= acc_b_d;
		end
	end

endmodule

FILE: hw/rtl/alias_method_sampler_xoroshiro.sv
`timescale 1ns / 1ps

// Alias-method token sampler with a xoroshiro128+ generator. A request is taken when start
// is high and busy is low; exactly one result word follows, shown on token and status for
// a single cycle with done high. The receiver cannot stall, so it must take every word the
// cycle it appears. Steps from the accepting edge to done: reseed, empty-table sample and
// slot write are done straight from idle (when TABLE_DEPTH is neither a power of two nor
// above 4096, slot and alias indexes are first each reduced through the shared multiplier
// in states MODQ, MODM and MODR, then written in a separate WR state); a sample runs the
// generator step (DRAW), two passes through the shared 32x17 multiplier (MLO, MHI), the
// single-port table read (RD), then PICK and, for a draw that reads the alias slot, ALIAS;
// skip redraws repeat that loop up to MAX_REDRAWS times; a jump walks every polynomial bit,
// stepping the generator between bits, and loads the accumulator on the last. Configuration
// is always ready and must only be written while the block is idle.
module alias_method_sampler_xoroshiro #(
	parameter int unsigned TABLE_DEPTH       = amsx_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned TOKEN_WIDTH       = amsx_pkg::DEF_TOKEN_WIDTH,
	parameter int unsigned CUT_FRACTION_BITS = amsx_pkg::DEF_CUT_FRACTION_BITS,
	parameter int unsigned MAX_REDRAWS       = amsx_pkg::DEF_MAX_REDRAWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [amsx_pkg::IDX_W-1:0]     slot_index,
	input  logic [amsx_pkg::CUT_W-1:0]     slot_cut,
	input  logic [amsx_pkg::IDX_W-1:0]     slot_alias,
	input  logic [amsx_pkg::TOK_W-1:0]     slot_token,
	output logic                           done,
	output logic [amsx_pkg::TOK_W-1:0]     token,
	output logic [1:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [amsx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [amsx_pkg::WORD_W-1:0]    cfg_data
);

	import amsx_pkg::*;

	localparam int unsigned AW  = $clog2(TABLE_DEPTH);
	localparam int unsigned TW  = (TOKEN_WIDTH < TOK_W) ? TOKEN_WIDTH : TOK_W;
	localparam int unsigned RW  = CUT_W + AW + TW;
	localparam int unsigned CW  = (CUT_FRACTION_BITS > CUT_W) ? CUT_FRACTION_BITS : CUT_W;
	localparam int unsigned FRAC_SHIFT = UNI_W - CUT_FRACTION_BITS;
	localparam int unsigned RCW = $clog2(MAX_REDRAWS + 1);
	localparam int unsigned JCW = $clog2(JUMP_STEPS);
	// index reduction needs the multiplier only for small non power-of-two depths
	localparam bit NEED_MOD = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) != 0) && (TABLE_DEPTH < 4096);
	localparam int unsigned MOD_S = IDX_W + AW;
	localparam int unsigned MOD_M = ((1 << MOD_S) + TABLE_DEPTH - 1) / TABLE_DEPTH;
	localparam int unsigned PLO_W = MUL_A_W + SIZE_W;
	localparam int unsigned PHI_W = (UNI_W - MUL_A_W) + SIZE_W;
	localparam int unsigned COMB_W = PHI_W + 1;
	localparam int unsigned SLOT_LSB = UNI_W - MUL_A_W;

	// configuration registers
	logic [SIZE_W-1:0] table_size_q;
	logic [TOK_W-1:0]  skip_id_q;
	logic              skip_en_q;
	logic [WORD_W-1:0] seed_low_q, seed_high_q;

	// sequencer state and counters
	state_t          state_q, state_d;
	logic [RCW-1:0]  cnt_q;
	logic [JCW-1:0]  jcnt_q;
	logic            mod_sel_q;
	logic            done_q;
	logic [TOK_W-1:0] token_q;
	status_t         status_q;

	// datapath registers
	logic [IDX_W-1:0]  x_idx_q, x_alias_q;
	logic [CUT_W-1:0]  cut_q;
	logic [TW-1:0]     tok_q;
	logic [AW-1:0]     idx_q, alias_q;
	logic [SIZE_W-1:0] n_q;
	logic [UNI_W-1:0]  u_q;
	logic [PLO_W-1:0]  plo_q;
	logic [CW-1:0]     frac_top_q;

	logic              accept;
	logic [SIZE_W-1:0] n_eff;
	gen_cmd_t          gen_cmd;
	logic [WORD_W-1:0] gen_sum;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [RW-1:0]     ram_wdata, ram_rdata;
	logic [CUT_W-1:0]  rd_cut;
	logic [AW-1:0]     rd_alias;
	logic [TOK_W-1:0]  rd_tok;
	logic              skip_hit, keep;
	logic [COMB_W-1:0] comb;
	logic [UNI_W-1:0]  frac;
	logic [IDX_W-1:0]  mod_x, mod_q, mod_r;
	logic              res_valid;
	logic [TOK_W-1:0]  res_token;
	status_t           res_status;
	logic              redraw;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign token     = token_q;
	assign status    = status_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
			skip_id_q    <= '0;
			skip_en_q    <= 1'b0;
			seed_low_q   <= SEED_LOW_RST;
			seed_high_q  <= SEED_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_SIZE:  table_size_q <= cfg_data[SIZE_W-1:0];
				CFG_SKIP_ID:     skip_id_q    <= cfg_data[TOK_W-1:0];
				CFG_SKIP_ENABLE: skip_en_q    <= cfg_data[0];
				CFG_SEED_LOW:    seed_low_q   <= cfg_data;
				CFG_SEED_HIGH:   seed_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective table size, clamped to the depth
	assign n_eff = ({{(32-SIZE_W){1'b0}}, table_size_q} > 32'(TABLE_DEPTH))
		? SIZE_W'(TABLE_DEPTH) : table_size_q;

	// units
	amsx_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (gen_cmd),
		.seed_low  (seed_low_q),
		.seed_high (seed_high_q),
		.sum       (gen_sum)
	);

	amsx_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	amsx_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// table word fields
	assign rd_cut   = ram_rdata[TW+AW +: CUT_W];
	assign rd_alias = ram_rdata[TW +: AW];
	assign rd_tok   = TOK_W'(ram_rdata[TW-1:0]);
	assign skip_hit = skip_en_q && (rd_tok == skip_id_q);
	assign keep     = frac_top_q < CW'(rd_cut);

	// fixed-point scaling of the uniform draw
	assign comb = COMB_W'(mul_p[PHI_W-1:0]) + COMB_W'(plo_q[PLO_W-1:MUL_A_W]);
	assign frac = {comb[SLOT_LSB-1:0], plo_q[MUL_A_W-1:0]};

	// index reduction by reciprocal
	assign mod_x = mod_sel_q ? x_alias_q : x_idx_q;
	assign mod_q = IDX_W'(mul_p >> MOD_S);
	assign mod_r = mod_x - mul_p[IDX_W-1:0];

	// sequencer next state and unit control
	always_comb begin
		state_d    = state_q;
		gen_cmd    = '0;
		mul_a      = '0;
		mul_b      = '0;
		ram_we     = 1'b0;
		ram_addr   = idx_q;
		ram_wdata  = {cut_q, alias_q, tok_q};
		res_valid  = 1'b0;
		res_token  = '0;
		res_status = ST_DONE;
		redraw     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_t'(req_type))
						REQ_WRITE: begin
							if (NEED_MOD) begin
								state_d = S_MODQ;
							end else begin
								ram_we    = 1'b1;
								ram_addr  = AW'(slot_index);
								ram_wdata = {slot_cut, AW'(slot_alias), slot_token[TW-1:0]};
								res_valid = 1'b1;
							end
						end
						REQ_SAMPLE: begin
							if (table_size_q == '0) begin
								res_valid  = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_d = S_DRAW;
							end
						end
						REQ_JUMP: begin
							gen_cmd.acc_clear = 1'b1;
							state_d = S_JUMP;
						end
						REQ_RESEED: begin
							gen_cmd.reseed = 1'b1;
							res_valid = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_MODQ: begin
				mul_a   = MUL_A_W'(mod_x);
				mul_b   = MUL_B_W'(MOD_M);
				state_d = S_MODM;
			end
			S_MODM: begin
				mul_a   = MUL_A_W'(mod_q);
				mul_b   = MUL_B_W'(TABLE_DEPTH);
				state_d = S_MODR;
			end
			S_MODR: begin
				state_d = mod_sel_q ? S_WR : S_MODQ;
			end
			S_WR: begin
				ram_we    = 1'b1;
				res_valid = 1'b1;
				state_d   = S_IDLE;
			end
			S_DRAW: begin
				gen_cmd.step = 1'b1;
				state_d = S_MLO;
			end
			S_MLO: begin
				mul_a   = u_q[MUL_A_W-1:0];
				mul_b   = MUL_B_W'(n_q);
				state_d = S_MHI;
			end
			S_MHI: begin
				mul_a   = MUL_A_W'(u_q[UNI_W-1:MUL_A_W]);
				mul_b   = MUL_B_W'(n_q);
				state_d = S_RD;
			end
			S_RD: begin
				ram_addr = AW'(comb[COMB_W-1:SLOT_LSB]);
				state_d  = S_PICK;
			end
			S_PICK, S_ALIAS: begin
				if (state_q == S_PICK && !keep) begin
					ram_addr = rd_alias;
					state_d  = S_ALIAS;
				end else if (!skip_hit) begin
					res_valid  = 1'b1;
					res_token  = rd_tok;
					res_status = ST_SAMPLED;
					state_d    = S_IDLE;
				end else if (cnt_q == RCW'(MAX_REDRAWS)) begin
					res_valid  = 1'b1;
					res_status = ST_EXHAUSTED;
					state_d    = S_IDLE;
				end else begin
					redraw  = 1'b1;
					state_d = S_DRAW;
				end
			end
			S_JUMP: begin
				gen_cmd.acc_xor = JUMP_POLY[jcnt_q];
				if (jcnt_q == JCW'(JUMP_STEPS - 1)) begin
					gen_cmd.acc_load = 1'b1;
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end else begin
					gen_cmd.step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			jcnt_q    <= '0;
			mod_sel_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (accept) begin
				cnt_q     <= '0;
				jcnt_q    <= '0;
				mod_sel_q <= 1'b0;
			end else begin
				if (redraw) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (state_q == S_JUMP) begin
					jcnt_q <= jcnt_q + 1'b1;
				end
				if (state_q == S_MODR) begin
					mod_sel_q <= 1'b1;
				end
			end
		end
	end

	// result word and datapath registers
	always_ff @(posedge clk) begin
		if (res_valid) begin
			token_q  <= res_token;
			status_q <= res_status;
		end
		if (accept) begin
			x_idx_q   <= slot_index;
			x_alias_q <= slot_alias;
			cut_q     <= slot_cut;
			tok_q     <= slot_token[TW-1:0];
			n_q       <= n_eff;
		end
		if (state_q == S_MODR) begin
			if (mod_sel_q) begin
				alias_q <= AW'(mod_r);
			end else begin
				idx_q <= AW'(mod_r);
			end
		end
		if (state_q == S_DRAW) begin
			u_q <= gen_sum[WORD_W-1:UNI_SHIFT];
		end
		if (state_q == S_MHI) begin
			plo_q <= mul_p[PLO_W-1:0];
		end
		if (state_q == S_RD) begin
			frac_top_q <= CW'(frac >> FRAC_SHIFT);
		end
	end

endmodule

FILE: hw/rtl/amsx_checker.sv
`timescale 1ns / 1ps
`include "alias_method_sampler_xoroshiro_defines.svh"

module amsx_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [amsx_pkg::TOK_W-1:0] token,
	input logic [1:0]                 status
);

	import amsx_pkg::*;

	// an accepted word either finishes at once or holds the block busy
	`AMSX_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)

	// token is zero unless the result is a successful sample
	`AMSX_ASSERT_NOW(a_token_zero, done && (status != ST_SAMPLED), token == '0)

	// the block leaves busy only with a result
	`AMSX_ASSERT_NOW(a_busy_ends_result, $fell(busy), done)

	// no result without a request behind it
	`AMSX_ASSERT_NOW(a_no_spurious, done, $past(busy) || $past(start))

endmodule

bind alias_method_sampler_xoroshiro amsx_checker u_amsx_checker (.*);

FILE: tb/alias_method_sampler_xoroshiro_tb.sv
`timescale 1ns / 1ps

module alias_method_sampler_xoroshiro_tb;
	import amsx_pkg::*;

	localparam int unsigned DEPTH          = 4096;
	localparam int unsigned REDRAW_LIMIT   = 64;
	localparam int unsigned PHASE_WORDS    = 160;
	localparam int unsigned IDLE_TAIL      = 4;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam logic [127:0] JUMP_TAPS = {64'h170865df4b3201fc, 64'hdf900294d8f554a5};

	typedef struct packed {
		logic [TOK_W-1:0] tok;
		status_t          stat;
	} sampler_word_t;

	// block ports
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 busy;
	logic [1:0]           req_type   = REQ_WRITE;
	logic [IDX_W-1:0]     slot_index = '0;
	logic [CUT_W-1:0]     slot_cut   = '0;
	logic [IDX_W-1:0]     slot_alias = '0;
	logic [TOK_W-1:0]     slot_token = '0;
	logic                 done;
	logic [TOK_W-1:0]     token;
	logic [1:0]           status;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = CFG_TABLE_SIZE;
	logic [WORD_W-1:0]    cfg_data   = '0;

	// sampler state as predicted
	logic [WORD_W-1:0] xo_a, xo_b;
	logic [CUT_W-1:0]  cut_mem [DEPTH];
	logic [IDX_W-1:0]  alt_mem [DEPTH];
	logic [TOK_W-1:0]  tok_mem [DEPTH];
	logic [SIZE_W-1:0] cfg_size;
	logic [TOK_W-1:0]  cfg_skip_id;
	logic              cfg_skip_en;
	logic [WORD_W-1:0] cfg_seed_lo, cfg_seed_hi;

	sampler_word_t pending_words [$];
	int fail_count   = 0;
	int burst_left   = 0;
	int stall_cycles = 0;

	alias_method_sampler_xoroshiro dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.slot_index (slot_index),
		.slot_cut   (slot_cut),
		.slot_alias (slot_alias),
		.slot_token (slot_token),
		.done       (done),
		.token      (token),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one xoroshiro128+ step, returns the sum of the old words
	function automatic logic [WORD_W-1:0] xoro_next();
		logic [WORD_W-1:0] a, b, sum;
		a = xo_a;
		b = xo_b;
		sum = a + b;
		b = b ^ a;
		xo_a = {a[39:0], a[63:40]} ^ b ^ (b << 16);
		xo_b = {b[26:0], b[63:27]};
		return sum;
	endfunction

	// expected result word for one request, updates the predicted state
	function automatic sampler_word_t predict_word(req_t rt, logic [IDX_W-1:0] idx,
			logic [CUT_W-1:0] cut, logic [IDX_W-1:0] alt, logic [TOK_W-1:0] tk);
		sampler_word_t w;
		logic [WORD_W-1:0] acc_a, acc_b;
		logic [65:0] prod, n;
		logic [IDX_W-1:0] slot, pick;
		logic [TOK_W-1:0] drawn;
		int draws;
		w.tok = '0;
		w.stat = ST_DONE;
		case (rt)
		REQ_WRITE: begin
			cut_mem[idx] = cut;
			alt_mem[idx] = alt;
			tok_mem[idx] = tk;
		end
		REQ_SAMPLE: begin
			n = (cfg_size > DEPTH) ? DEPTH : cfg_size;
			if (n == 0) begin
				w.stat = ST_EMPTY;
			end else begin
				w.stat = ST_EXHAUSTED;
				draws = 0;
				while (w.stat == ST_EXHAUSTED && draws <= REDRAW_LIMIT) begin
					// 53-bit uniform times size: integer part is the slot
					prod = xoro_next() >> 11;
					prod = prod * n;
					slot = prod[64:53];
					pick = ({1'b0, prod[52:37]} < cut_mem[slot]) ? slot : alt_mem[slot];
					drawn = tok_mem[pick];
					if (!(cfg_skip_en && drawn == cfg_skip_id)) begin
						w.tok = drawn;
						w.stat = ST_SAMPLED;
					end
					draws++;
				end
			end
		end
		REQ_JUMP: begin
			acc_a = '0;
			acc_b = '0;
			for (int tap = 0; tap < 128; tap++) begin
				if (JUMP_TAPS[tap]) begin
					acc_a ^= xo_a;
					acc_b ^= xo_b;
				end
				void'(xoro_next());
			end
			xo_a = acc_a;
			xo_b = acc_b;
		end
		REQ_RESEED: begin
			xo_a = cfg_seed_lo;
			xo_b = cfg_seed_hi;
		end
		default: ;
		endcase
		return w;
	endfunction

	// cut values spread over zero, below, at and above full scale
	function automatic logic [CUT_W-1:0] pick_cut();
		logic [CUT_W-1:0] c;
		case ($urandom_range(0, 7))
		0: c = '0;
		1: c = CUT_W'(65536);
		2: c = CUT_W'($urandom_range(65537, 131071));
		3: c = '1;
		default: c = CUT_W'($urandom_range(0, 65535));
		endcase
		return c;
	endfunction

	// half the tokens from a tiny pool so skip ids repeat
	function automatic logic [TOK_W-1:0] pick_token();
		if ($urandom_range(0, 1))
			return TOK_W'($urandom);
		return TOK_W'($urandom_range(0, 3));
	endfunction

	// send one request word, predict its result, then pace the sender
	task automatic send_req(req_t rt, logic [IDX_W-1:0] idx, logic [CUT_W-1:0] cut,
			logic [IDX_W-1:0] alt, logic [TOK_W-1:0] tk);
		start <= 1'b1;
		req_type <= rt;
		slot_index <= idx;
		slot_cut <= cut;
		slot_alias <= alt;
		slot_token <= tk;
		do @(posedge clk); while (busy);
		pending_words.push_back(predict_word(rt, idx, cut, alt, tk));
		// bursts of back-to-back words with random gaps between them
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// stop sending and wait for every owed word
	task automatic settle_idle();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// register write, only while idle
	task automatic write_cfg(cfg_idx_t idx, logic [WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_TABLE_SIZE:  cfg_size = data[SIZE_W-1:0];
		CFG_SKIP_ID:     cfg_skip_id = data[TOK_W-1:0];
		CFG_SKIP_ENABLE: cfg_skip_en = data[0];
		CFG_SEED_LOW:    cfg_seed_lo = data;
		CFG_SEED_HIGH:   cfg_seed_hi = data;
		default: ;
		endcase
		@(posedge clk);
	endtask

	// empty table after reset, plus the other requests on it
	task automatic test_empty_table();
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_WRITE, '1, '1, '1, '1);
		send_req(REQ_JUMP, '0, '0, '0, '0);
		send_req(REQ_RESEED, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '1, '1, '1, '1);
		settle_idle();
	endtask

	// every slot written once so no sample reads an unwritten entry
	task automatic test_fill_table();
		for (int i = 0; i < DEPTH; i++)
			send_req(REQ_WRITE, IDX_W'(i), pick_cut(), IDX_W'($urandom), pick_token());
		settle_idle();
	endtask

	task automatic test_corner_draws();
		// single slot: cut decides between slot 0 and its alias
		write_cfg(CFG_TABLE_SIZE, 64'd1);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_WRITE, 12'd0, 17'd0, 12'hfff, 16'h1234);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_WRITE, 12'd0, 17'h10000, 12'd7, 16'h0000);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		// full and oversized table
		write_cfg(CFG_TABLE_SIZE, 64'd4096);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		write_cfg(CFG_TABLE_SIZE, 64'd8191);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		// all-ones seed, then jump ahead
		write_cfg(CFG_SEED_LOW, '1);
		write_cfg(CFG_SEED_HIGH, '1);
		send_req(REQ_RESEED, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_JUMP, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		// all-zero seed pins every draw to slot 0
		write_cfg(CFG_SEED_LOW, '0);
		write_cfg(CFG_SEED_HIGH, '0);
		send_req(REQ_RESEED, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		// every draw gives the skip id: retries run out
		write_cfg(CFG_TABLE_SIZE, 64'd1);
		write_cfg(CFG_SKIP_ID, 64'hbeef);
		write_cfg(CFG_SKIP_ENABLE, 64'd1);
		send_req(REQ_WRITE, 12'd0, 17'h1ffff, 12'd0, 16'hbeef);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		// two slots, slot 0 always skipped
		write_cfg(CFG_SEED_LOW, {$urandom, $urandom});
		write_cfg(CFG_SEED_HIGH, {$urandom, $urandom});
		write_cfg(CFG_TABLE_SIZE, 64'd2);
		send_req(REQ_WRITE, 12'd1, 17'h10000, 12'd1, 16'h0001);
		send_req(REQ_RESEED, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		send_req(REQ_SAMPLE, '0, '0, '0, '0);
		settle_idle();
		write_cfg(CFG_SKIP_ID, 64'hffff);
		write_cfg(CFG_SKIP_ENABLE, 64'd0);
	endtask

	task automatic test_random_traffic();
		logic [SIZE_W-1:0] size;
		int unsigned lim, roll;
		logic [IDX_W-1:0] idx;
		req_t rt;
		for (int ph = 0; ph < 8; ph++) begin
			settle_idle();
			// phase settings, extremes first
			case (ph)
			0: size = 1;
			1: size = 4096;
			2: size = SIZE_W'($urandom_range(4097, 8191));
			3: size = 2;
			4: size = 0;
			5: size = SIZE_W'($urandom_range(3, 64));
			default: size = SIZE_W'($urandom_range(1, 4096));
			endcase
			lim = (size > DEPTH) ? DEPTH : size;
			write_cfg(CFG_TABLE_SIZE, 64'(size));
			write_cfg(CFG_SKIP_ENABLE, 64'(ph % 2 == 0));
			if (lim != 0 && $urandom_range(0, 3) != 0)
				write_cfg(CFG_SKIP_ID, 64'(tok_mem[$urandom_range(0, lim - 1)]));
			else
				write_cfg(CFG_SKIP_ID, 64'($urandom_range(0, 65535)));
			write_cfg(CFG_SEED_LOW, {$urandom, $urandom});
			write_cfg(CFG_SEED_HIGH, {$urandom, $urandom});
			for (int i = 0; i < PHASE_WORDS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 68)
					rt = REQ_SAMPLE;
				else if (roll < 84)
					rt = REQ_WRITE;
				else if (roll < 95)
					rt = REQ_RESEED;
				else
					rt = REQ_JUMP;
				// writes favor the slots in use
				if (lim != 0 && $urandom_range(0, 1))
					idx = IDX_W'($urandom_range(0, lim - 1));
				else
					idx = IDX_W'($urandom);
				send_req(rt, idx, pick_cut(), IDX_W'($urandom), pick_token());
			end
		end
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin : check_words
		sampler_word_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: token %0h status %0d", token, status);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (token !== want.tok) begin
					$error("token mismatch: expected %0h, actual %0h", want.tok, token);
					fail_count++;
				end
				if (status !== want.stat) begin
					$error("status mismatch: expected %0d, actual %0d", want.stat, status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		xo_a = 64'd1;
		xo_b = 64'd0;
		cfg_size = '0;
		cfg_skip_id = '0;
		cfg_skip_en = 1'b0;
		cfg_seed_lo = 64'd1;
		cfg_seed_hi = 64'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_table();
		test_corner_draws();
		test_random_traffic();
		settle_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
